@@ rtl/core/swtg_pkg.sv @@
// Shared types, constants and helpers for the square-wave tone generator.
// No dependencies; every other file in rtl/core imports this package.
package swtg_pkg;

  localparam int unsigned CPU_HZ      = 8000000;
  localparam int unsigned CPU_W       = $clog2(CPU_HZ + 1);
  localparam int unsigned PSC_CODES   = 15;
  localparam int unsigned PCNT_W      = 14;
  localparam int unsigned QUOT_W      = 8;
  localparam int unsigned STEP_W      = $clog2(QUOT_W + 1);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  PIN_NONE    = 8'hFF;
  localparam logic [7:0]  QUOT_MAX    = 8'hFF;
  localparam logic [31:0] LEN_FOREVER = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_CLK   = 2'd2,
    OP_MS    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_TONE,
    CMD_HALT,
    CMD_CLK,
    CMD_MS
  } cmd_e;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } back_state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [7:0]        pin;
    logic [15:0]       freq;
    logic [31:0]       len;
    logic [3:0]        psel;
    logic              sat;
    logic [CPU_W-1:0]  dividend;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [CPU_W-1:0]  dividend;
    logic [15:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [CPU_W-1:0] psc_dividend(logic [3:0] code);
    logic [31:0] shifted;
    shifted = (code == 4'd0) ? 32'(CPU_HZ) : (32'(CPU_HZ) >> (code - 4'd1));
    return shifted[CPU_W-1:0];
  endfunction

endpackage

@@ rtl/core/square_wave_tone_generator_top.sv @@
// Path: an accepted beat is written to the queue, popped by the back end, then registered.
// Throughput: 1 beat per cycle when not stalled; an unsaturated tone start that changes
// pin or frequency holds the back end while the 8-step divider forms the compare value.
// Reset: asynchronous, active low; clears queue, timer, clocks, valid; active pin is 255.
// Depends on swtg_pkg, swtg_front, swtg_queue, swtg_div and swtg_back.
module square_wave_tone_generator_top import swtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  pin_i,
  input  logic [15:0] frequency_i,
  input  logic [31:0] length_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pin_id_o,
  output logic        pin_level_o,
  output logic        playing_o,
  output logic [7:0]  released_pin_o,
  output logic [7:0]  compare_value_o,
  output logic [3:0]  prescale_code_o,
  output logic        toggled_o
);

  cmd_t     push_entry, head_entry;
  logic     push, pop, q_empty, q_full;
  div_req_t div_req;
  div_rsp_t div_rsp;

  swtg_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .pin_i       (pin_i),
    .frequency_i (frequency_i),
    .length_ms_i (length_ms_i),
    .full_i      (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  swtg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  swtg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  swtg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_i         (head_entry),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pin_id_o        (pin_id_o),
    .pin_level_o     (pin_level_o),
    .playing_o       (playing_o),
    .released_pin_o  (released_pin_o),
    .compare_value_o (compare_value_o),
    .prescale_code_o (prescale_code_o),
    .toggled_o       (toggled_o)
  );

endmodule

@@ rtl/core/swtg_front.sv @@
// Front end: accepts input beats, classifies them and picks the prescale code.
// Depends on swtg_pkg; feeds swtg_queue.
module swtg_front import swtg_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  pin_i,
  input  logic [15:0] frequency_i,
  input  logic [31:0] length_ms_i,
  input  logic        full_i,
  output logic        push_o,
  output cmd_t        entry_o
);

  logic [3:0]  fit_psel;
  logic        fit_sat;
  logic [31:0] freq_scaled;

  assign freq_scaled = {8'b0, frequency_i, 8'b0};

  // smallest code whose divided clock stays below 256 periods
  always_comb begin
    fit_psel = 4'(PSC_CODES);
    fit_sat  = 1'b1;
    for (int j = PSC_CODES - 1; j >= 0; j--) begin
      if ((32'(CPU_HZ) >> j) < freq_scaled) begin
        fit_psel = 4'(j + 1);
        fit_sat  = 1'b0;
      end
    end
  end

  always_comb begin
    entry_o.pin      = pin_i;
    entry_o.freq     = frequency_i;
    entry_o.len      = length_ms_i;
    entry_o.psel     = fit_psel;
    entry_o.sat      = fit_sat;
    entry_o.dividend = psc_dividend(fit_psel);
    case (op_e'(op_i))
      OP_START: entry_o.cmd = (frequency_i == 16'd0) ? CMD_HALT : CMD_TONE;
      OP_STOP:  entry_o.cmd = CMD_HALT;
      OP_CLK:   entry_o.cmd = CMD_CLK;
      default:  entry_o.cmd = CMD_MS;
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

@@ rtl/core/swtg_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on swtg_pkg.
module swtg_queue import swtg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  entry_i,
  input  logic  pop_i,
  output cmd_t  entry_o,
  output logic  empty_o,
  output logic  full_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/core/swtg_div.sv @@
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on swtg_pkg; used by swtg_back for the compare value.
module swtg_div import swtg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic [15:0]       rem_q, rem_d;
  logic [15:0]       dvs_q, dvs_d;
  logic [QUOT_W-1:0] low_q, low_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [16:0]       trial;
  logic [31:0]       hi_part;

  assign hi_part = 32'(req_i.dividend >> QUOT_W);
  assign trial   = {rem_q, low_q[QUOT_W-1]};

  always_comb begin
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    low_d  = low_q;
    quot_d = quot_q;
    if (req_i.start) begin
      step_d = STEP_W'(QUOT_W);
      rem_d  = hi_part[15:0];
      dvs_d  = req_i.divisor;
      low_d  = req_i.dividend[QUOT_W-1:0];
      quot_d = '0;
    end else if (step_q != '0) begin
      step_d = step_q - 1'b1;
      low_d  = {low_q[QUOT_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = 16'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[QUOT_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[15:0];
        quot_d = {quot_q[QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = (step_q == '0);
  assign rsp_o.quot = quot_q;

endmodule

@@ rtl/core/swtg_back.sv @@
// Back end: tone state, prescaler, 8-bit timer, duration check, result register.
// Depends on swtg_pkg; drains swtg_queue and drives swtg_div.
module swtg_back import swtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        entry_i,
  input  logic        empty_i,
  output logic        pop_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pin_id_o,
  output logic        pin_level_o,
  output logic        playing_o,
  output logic [7:0]  released_pin_o,
  output logic [7:0]  compare_value_o,
  output logic [3:0]  prescale_code_o,
  output logic        toggled_o
);

  back_state_e       state_q, state_d;

  logic [15:0]       last_freq_q, last_freq_d;
  logic [31:0]       dur_q, dur_d;
  logic [31:0]       stamp_q, stamp_d;
  logic [7:0]        active_q, active_d;
  logic [31:0]       ms_q, ms_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;
  logic [7:0]        tcnt_q, tcnt_d;
  logic [7:0]        top_q, top_d;
  logic [3:0]        psel_q, psel_d;
  logic              level_q, level_d;
  logic              on_q, on_d;

  logic [7:0]        pend_pin_q;
  logic [15:0]       pend_freq_q;
  logic [3:0]        pend_psel_q;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        o_pin_q, o_rel_q, o_top_q;
  logic              o_level_q, o_play_q, o_tog_q;
  logic [3:0]        o_psel_q;

  logic              slot_free, tone_new, needs_div, apply, emit;
  logic [7:0]        a_pin, a_quot;
  logic [15:0]       a_freq;
  logic [3:0]        a_psel;
  logic [7:0]        rel;
  logic              tog;
  logic [PCNT_W:0]   pn, pdiv;
  logic [31:0]       elapsed;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign tone_new  = (entry_i.pin != active_q) || (entry_i.freq != last_freq_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (needs_div) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done && slot_free) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    needs_div = 1'b0;
    apply     = 1'b0;
    emit      = 1'b0;
    a_pin     = entry_i.pin;
    a_freq    = entry_i.freq;
    a_psel    = entry_i.psel;
    a_quot    = QUOT_MAX;
    case (state_q)
      ST_RUN: begin
        pop_o     = !empty_i && slot_free;
        needs_div = pop_o && (entry_i.cmd == CMD_TONE) && tone_new && !entry_i.sat;
        apply     = pop_o && (entry_i.cmd == CMD_TONE) && tone_new && entry_i.sat;
        emit      = pop_o && !needs_div;
      end
      ST_DIV: begin
        apply  = div_rsp_i.done && slot_free;
        emit   = apply;
        a_pin  = pend_pin_q;
        a_freq = pend_freq_q;
        a_psel = pend_psel_q;
        a_quot = div_rsp_i.quot;
      end
      default: ;
    endcase
  end

  assign div_req_o.start    = needs_div;
  assign div_req_o.dividend = entry_i.dividend;
  assign div_req_o.divisor  = entry_i.freq;

  assign pn      = {1'b0, pcnt_q} + 1'b1;
  assign pdiv    = (PCNT_W + 1)'(1) << (psel_q - 4'd1);
  assign elapsed = ms_q - stamp_q;

  always_comb begin
    last_freq_d = last_freq_q;
    dur_d       = dur_q;
    stamp_d     = stamp_q;
    active_d    = active_q;
    ms_d        = ms_q;
    pcnt_d      = pcnt_q;
    tcnt_d      = tcnt_q;
    top_d       = top_q;
    psel_d      = psel_q;
    level_d     = level_q;
    on_d        = on_q;
    rel         = PIN_NONE;
    tog         = 1'b0;
    if (pop_o) begin
      case (entry_i.cmd)
        CMD_TONE: begin
          dur_d = (entry_i.len == 32'd0) ? LEN_FOREVER : entry_i.len;
        end
        CMD_HALT: begin
          rel      = (entry_i.pin == PIN_NONE) ? active_q : entry_i.pin;
          on_d     = 1'b0;
          active_d = PIN_NONE;
        end
        CMD_CLK: begin
          if (psel_q != 4'd0) begin
            if (pn >= pdiv) begin
              pcnt_d = '0;
              if (tcnt_q == top_q) begin
                tcnt_d = 8'd0;
                if (on_q) begin
                  level_d = ~level_q;
                  tog     = 1'b1;
                  if (elapsed >= dur_q) begin
                    rel      = active_q;
                    on_d     = 1'b0;
                    active_d = PIN_NONE;
                  end
                end
              end else begin
                tcnt_d = tcnt_q + 8'd1;
              end
            end else begin
              pcnt_d = pn[PCNT_W-1:0];
            end
          end
        end
        default: begin
          ms_d = ms_q + 32'd1;
        end
      endcase
    end
    if (apply) begin
      last_freq_d = a_freq;
      if (a_pin != active_q) begin
        active_d = a_pin;
        level_d  = 1'b1;
      end
      top_d   = a_quot;
      psel_d  = a_psel;
      stamp_d = ms_q;
      on_d    = 1'b1;
    end
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      last_freq_q <= '0;
      dur_q       <= '0;
      stamp_q     <= '0;
      active_q    <= PIN_NONE;
      ms_q        <= '0;
      pcnt_q      <= '0;
      tcnt_q      <= '0;
      top_q       <= '0;
      psel_q      <= '0;
      level_q     <= 1'b0;
      on_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_freq_q <= last_freq_d;
      dur_q       <= dur_d;
      stamp_q     <= stamp_d;
      active_q    <= active_d;
      ms_q        <= ms_d;
      pcnt_q      <= pcnt_d;
      tcnt_q      <= tcnt_d;
      top_q       <= top_d;
      psel_q      <= psel_d;
      level_q     <= level_d;
      on_q        <= on_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (needs_div) begin
      pend_pin_q  <= entry_i.pin;
      pend_freq_q <= entry_i.freq;
      pend_psel_q <= entry_i.psel;
    end
    if (emit) begin
      o_pin_q   <= active_d;
      o_level_q <= level_d;
      o_play_q  <= on_d;
      o_rel_q   <= rel;
      o_top_q   <= top_d;
      o_psel_q  <= psel_d;
      o_tog_q   <= tog;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pin_id_o        = o_pin_q;
  assign pin_level_o     = o_level_q;
  assign playing_o       = o_play_q;
  assign released_pin_o  = o_rel_q;
  assign compare_value_o = o_top_q;
  assign prescale_code_o = o_psel_q;
  assign toggled_o       = o_tog_q;

endmodule
